// ===== sv/string_intern_table_defines.svh =====
// assertion macros shared by the string intern table
`ifndef STRING_INTERN_TABLE_DEFINES_SVH
`define STRING_INTERN_TABLE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define SIT_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// invariant that holds at every clock edge outside reset
`define SIT_ASSERT_ALWAYS(name, clk, rstn, cons, msg) \
    `SIT_ASSERT_IMPL(name, clk, rstn, 1'b1, cons, msg)

`endif

// ===== sv/sit_pkg.sv =====
`timescale 1ns / 1ps

package sit_pkg;

    localparam int MAX_WORD_BYTES_DEF = 32;
    localparam int BUCKET_COUNT_DEF   = 256;
    localparam int MAX_ENTRIES_DEF    = 128;
    localparam int STORE_BYTES_DEF    = 4096;

    localparam int HASH_W       = 32;
    localparam int SYM_W        = 8;
    localparam int RB_LEN_W     = 6;
    localparam int RESULT_LIMIT = 32;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] OP_INTERN = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [1:0] ST_BAD_STATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_BKT_RD,
        S_BKT_CHK,
        S_ENT_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_LK_RD,
        S_LK_CHK,
        S_INS,
        S_CP_RD,
        S_CP_WR,
        S_CP_FIN,
        S_RB_ENT,
        S_RB_RD,
        S_RB_OUT,
        S_EMIT
    } state_t;

endpackage

// ===== sv/string_intern_table.sv =====
`timescale 1ns / 1ps
// String intern table.
// Input channel s_*: one item per string byte (operation intern or lookup,
// byte_present, last_byte), or one item for a text readback (operation 2,
// symbol_query). Result channel m_*: one item per finished string, one per
// readback byte (at most 32), or one status item.
// A byte item without last_byte leaves the table idle and gives no result.
// At a string end the sequencer probes the bucket table from the hash's low
// bits, reading each bucket and then its entry record, compares stored text
// byte by byte against the word buffer and, on a miss at an empty bucket,
// copies the new string byte by byte into the text store; a lookup walks the
// entries in id order, comparing length and then text. A readback reads its
// bytes one after another, each waiting on m_ready before the next is read.
// s_ready is low while a string end, a readback or a status item is at work.
// After reset a clearing pass writes every bucket to empty, with s_ready low.
// A stalled m_ready holds the result item in the output register; the
// sequencer waits before loading the next one, while plain byte items are
// still taken.
`include "string_intern_table_defines.svh"

module string_intern_table #(
    parameter int MAX_WORD_BYTES = sit_pkg::MAX_WORD_BYTES_DEF,
    parameter int BUCKET_COUNT   = sit_pkg::BUCKET_COUNT_DEF,
    parameter int MAX_ENTRIES    = sit_pkg::MAX_ENTRIES_DEF,
    parameter int STORE_BYTES    = sit_pkg::STORE_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_text_byte,
    input  logic       s_byte_present,
    input  logic       s_last_byte,
    input  logic [7:0] s_symbol_query,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_symbol_id,
    output logic       m_found,
    output logic [1:0] m_status,
    output logic [7:0] m_text_out,
    output logic       m_text_valid,
    output logic       m_last_result
);

    localparam int HW  = sit_pkg::HASH_W;
    localparam int LW  = $clog2(MAX_WORD_BYTES + 1);
    localparam int WAW = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
    localparam int IDW = $clog2(MAX_ENTRIES + 1);
    localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int BAW = $clog2(BUCKET_COUNT);
    localparam int PW  = BAW + 1;
    localparam int SAW = $clog2(STORE_BYTES);
    localparam int UW  = $clog2(STORE_BYTES + 1);
    localparam int QW  = (IDW > sit_pkg::SYM_W) ? IDW : sit_pkg::SYM_W;
    localparam int IW  = sit_pkg::RB_LEN_W;
    localparam int CW  = IW + 1;
    localparam int EW  = HW + SAW + LW;

    sit_pkg::state_t state_reg, state_next;

    logic [LW-1:0]  word_len_reg, word_len_next;
    logic           too_long_reg, too_long_next;
    logic [HW-1:0]  hash_reg, hash_next;
    logic [IDW-1:0] count_reg, count_next;
    logic [UW-1:0]  used_reg, used_next;
    logic [1:0]     op_reg, op_next;
    logic [BAW-1:0] b_reg, b_next;
    logic [PW-1:0]  probes_reg, probes_next;
    logic [IDW-1:0] e_reg, e_next;
    logic [SAW-1:0] off_reg, off_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [IW-1:0]  rb_len_reg, rb_len_next;
    logic [7:0]     q_reg, q_next;
    logic [IDW-1:0] res_id_reg, res_id_next;
    logic           res_found_reg, res_found_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic           clrw_reg, clrw_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_symbol_id_reg, m_symbol_id_next;
    logic       m_found_reg, m_found_next;
    logic [1:0] m_status_reg, m_status_next;
    logic [7:0] m_text_out_reg, m_text_out_next;
    logic       m_text_valid_reg, m_text_valid_next;
    logic       m_last_result_reg, m_last_result_next;

    logic           wb_we;
    logic [WAW-1:0] wb_waddr, wb_raddr;
    logic [7:0]     wb_q;
    logic           ts_we;
    logic [SAW-1:0] ts_waddr, ts_raddr;
    logic [7:0]     ts_wdata, ts_q;
    logic           en_we;
    logic [EAW-1:0] en_waddr, en_raddr;
    logic [EW-1:0]  en_wdata, en_q;
    logic           bk_we;
    logic [BAW-1:0] bk_waddr;
    logic [IDW-1:0] bk_wdata, bk_q;

    logic [HW-1:0]  hash_step;
    logic [HW-1:0]  ent_hash;
    logic [SAW-1:0] ent_off;
    logic [LW-1:0]  ent_len;

    logic acc, is_str, out_free, q_bad, ent_key_eq, ent_len_eq, cmp_last;
    logic bkt_stale, probes_done, lk_done, store_fail, rb_last;
    logic [CW-1:0] rb_lim;

    assign acc      = s_valid && s_ready;
    assign is_str   = (s_operation == sit_pkg::OP_INTERN) ||
                      (s_operation == sit_pkg::OP_LOOKUP);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == sit_pkg::S_IDLE);

    assign {ent_hash, ent_off, ent_len} = en_q;
    assign ent_len_eq  = (ent_len == word_len_reg);
    assign ent_key_eq  = ent_len_eq && (ent_hash == hash_reg);
    assign cmp_last    = (CW'(i_reg) + CW'(1)) == CW'(word_len_reg);
    assign rb_last     = (CW'(i_reg) + CW'(1)) == CW'(rb_len_reg);
    assign bkt_stale   = bk_q > count_reg;
    assign probes_done = (probes_reg + PW'(1)) >= PW'(BUCKET_COUNT);
    assign lk_done     = (e_reg + IDW'(1)) >= count_reg;
    assign q_bad       = (s_symbol_query == 8'd0) ||
                         (QW'(s_symbol_query) > QW'(count_reg));
    assign store_fail  = ((UW + 1)'(word_len_reg) + (UW + 1)'(1)) >
                         ((UW + 1)'(STORE_BYTES) - (UW + 1)'(used_reg));
    assign rb_lim      = (CW'(ent_len) > CW'(sit_pkg::RESULT_LIMIT)) ?
                         CW'(sit_pkg::RESULT_LIMIT) : CW'(ent_len);

    sit_hash u_hash (
        .hash_in  (hash_reg),
        .byte_in  (s_text_byte),
        .hash_out (hash_step)
    );

    sit_ram #(.WIDTH(8), .DEPTH(MAX_WORD_BYTES)) u_word_ram (
        .aclk  (aclk),
        .we    (wb_we),
        .waddr (wb_waddr),
        .wdata (s_text_byte),
        .raddr (wb_raddr),
        .rdata (wb_q)
    );

    sit_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_text_ram (
        .aclk  (aclk),
        .we    (ts_we),
        .waddr (ts_waddr),
        .wdata (ts_wdata),
        .raddr (ts_raddr),
        .rdata (ts_q)
    );

    sit_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .aclk  (aclk),
        .we    (en_we),
        .waddr (en_waddr),
        .wdata (en_wdata),
        .raddr (en_raddr),
        .rdata (en_q)
    );

    sit_ram #(.WIDTH(IDW), .DEPTH(BUCKET_COUNT)) u_bucket_ram (
        .aclk  (aclk),
        .we    (bk_we),
        .waddr (bk_waddr),
        .wdata (bk_wdata),
        .raddr (b_reg),
        .rdata (bk_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sit_pkg::S_CLEAR: begin
                if (b_reg == BAW'(BUCKET_COUNT - 1)) begin
                    state_next = sit_pkg::S_IDLE;
                end
            end
            sit_pkg::S_IDLE: begin
                if (acc) begin
                    if (s_operation == sit_pkg::OP_READ) begin
                        state_next = q_bad ? sit_pkg::S_EMIT : sit_pkg::S_RB_ENT;
                    end else if (is_str) begin
                        if (s_last_byte) begin
                            state_next = sit_pkg::S_DECIDE;
                        end
                    end else begin
                        state_next = sit_pkg::S_EMIT;
                    end
                end
            end
            sit_pkg::S_DECIDE: begin
                if (too_long_reg) begin
                    state_next = sit_pkg::S_EMIT;
                end else if (op_reg == sit_pkg::OP_INTERN) begin
                    state_next = sit_pkg::S_BKT_RD;
                end else if (count_reg == '0) begin
                    state_next = sit_pkg::S_EMIT;
                end else begin
                    state_next = sit_pkg::S_LK_RD;
                end
            end
            sit_pkg::S_BKT_RD: state_next = sit_pkg::S_BKT_CHK;
            sit_pkg::S_BKT_CHK: begin
                if (bk_q == '0) begin
                    state_next = sit_pkg::S_INS;
                end else if (bkt_stale) begin
                    state_next = sit_pkg::S_EMIT;
                end else begin
                    state_next = sit_pkg::S_ENT_CHK;
                end
            end
            sit_pkg::S_ENT_CHK: begin
                if (ent_key_eq) begin
                    state_next = (word_len_reg == '0) ? sit_pkg::S_EMIT : sit_pkg::S_CMP_RD;
                end else begin
                    state_next = probes_done ? sit_pkg::S_EMIT : sit_pkg::S_BKT_RD;
                end
            end
            sit_pkg::S_CMP_RD: state_next = sit_pkg::S_CMP_CHK;
            sit_pkg::S_CMP_CHK: begin
                if (ts_q != wb_q) begin
                    if (op_reg == sit_pkg::OP_INTERN) begin
                        state_next = probes_done ? sit_pkg::S_EMIT : sit_pkg::S_BKT_RD;
                    end else begin
                        state_next = lk_done ? sit_pkg::S_EMIT : sit_pkg::S_LK_RD;
                    end
                end else if (cmp_last) begin
                    state_next = sit_pkg::S_EMIT;
                end else begin
                    state_next = sit_pkg::S_CMP_RD;
                end
            end
            sit_pkg::S_LK_RD: state_next = sit_pkg::S_LK_CHK;
            sit_pkg::S_LK_CHK: begin
                if (ent_len_eq) begin
                    state_next = (word_len_reg == '0) ? sit_pkg::S_EMIT : sit_pkg::S_CMP_RD;
                end else begin
                    state_next = lk_done ? sit_pkg::S_EMIT : sit_pkg::S_LK_RD;
                end
            end
            sit_pkg::S_INS: begin
                if ((count_reg >= IDW'(MAX_ENTRIES)) || store_fail) begin
                    state_next = sit_pkg::S_EMIT;
                end else if (word_len_reg == '0) begin
                    state_next = sit_pkg::S_CP_FIN;
                end else begin
                    state_next = sit_pkg::S_CP_RD;
                end
            end
            sit_pkg::S_CP_RD: state_next = sit_pkg::S_CP_WR;
            sit_pkg::S_CP_WR: begin
                state_next = cmp_last ? sit_pkg::S_CP_FIN : sit_pkg::S_CP_RD;
            end
            sit_pkg::S_CP_FIN: state_next = sit_pkg::S_EMIT;
            sit_pkg::S_RB_ENT: begin
                state_next = (rb_lim == '0) ? sit_pkg::S_EMIT : sit_pkg::S_RB_RD;
            end
            sit_pkg::S_RB_RD: state_next = sit_pkg::S_RB_OUT;
            sit_pkg::S_RB_OUT: begin
                if (out_free) begin
                    state_next = rb_last ? sit_pkg::S_IDLE : sit_pkg::S_RB_RD;
                end
            end
            sit_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = sit_pkg::S_IDLE;
                end
            end
            default: state_next = sit_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        word_len_next   = word_len_reg;
        too_long_next   = too_long_reg;
        hash_next       = hash_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        op_next         = op_reg;
        b_next          = b_reg;
        probes_next     = probes_reg;
        e_next          = e_reg;
        off_next        = off_reg;
        i_next          = i_reg;
        rb_len_next     = rb_len_reg;
        q_next          = q_reg;
        res_id_next     = res_id_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        clrw_next       = clrw_reg;

        m_valid_next       = m_valid_reg && !m_ready;
        m_symbol_id_next   = m_symbol_id_reg;
        m_found_next       = m_found_reg;
        m_status_next      = m_status_reg;
        m_text_out_next    = m_text_out_reg;
        m_text_valid_next  = m_text_valid_reg;
        m_last_result_next = m_last_result_reg;

        wb_we    = 1'b0;
        wb_waddr = WAW'(word_len_reg);
        wb_raddr = WAW'(i_reg);
        ts_we    = 1'b0;
        ts_waddr = SAW'(used_reg) + SAW'(i_reg);
        ts_wdata = wb_q;
        ts_raddr = off_reg + SAW'(i_reg);
        en_we    = 1'b0;
        en_waddr = EAW'(count_reg);
        en_wdata = {hash_reg, SAW'(used_reg), word_len_reg};
        en_raddr = EAW'(e_reg);
        bk_we    = 1'b0;
        bk_waddr = b_reg;
        bk_wdata = count_reg + IDW'(1);

        case (state_reg)
            sit_pkg::S_CLEAR: begin
                bk_we    = 1'b1;
                bk_wdata = '0;
                b_next   = b_reg + BAW'(1);
            end
            sit_pkg::S_IDLE: begin
                en_raddr = EAW'(s_symbol_query - 8'd1);
                if (acc) begin
                    op_next        = s_operation;
                    q_next         = s_symbol_query;
                    res_found_next = 1'b0;
                    if (s_operation == sit_pkg::OP_READ) begin
                        clrw_next       = 1'b0;
                        res_id_next     = '0;
                        res_status_next = sit_pkg::ST_BAD_ARG;
                    end else if (is_str) begin
                        clrw_next = 1'b1;
                        if (s_byte_present) begin
                            hash_next = hash_step;
                            if (word_len_reg < LW'(MAX_WORD_BYTES)) begin
                                wb_we         = 1'b1;
                                word_len_next = word_len_reg + LW'(1);
                            end else begin
                                too_long_next = 1'b1;
                            end
                        end
                    end else begin
                        clrw_next       = 1'b0;
                        res_id_next     = '0;
                        res_status_next = sit_pkg::ST_BAD_ARG;
                    end
                end
            end
            sit_pkg::S_DECIDE: begin
                res_id_next     = '0;
                res_status_next = too_long_reg ? sit_pkg::ST_BAD_ARG : sit_pkg::ST_OK;
                b_next          = hash_reg[BAW-1:0];
                probes_next     = '0;
                e_next          = '0;
            end
            sit_pkg::S_BKT_CHK: begin
                en_raddr        = EAW'(bk_q - IDW'(1));
                e_next          = bk_q - IDW'(1);
                res_status_next = sit_pkg::ST_BAD_STATE;
            end
            sit_pkg::S_ENT_CHK: begin
                off_next = ent_off;
                i_next   = '0;
                if (ent_key_eq) begin
                    res_id_next     = e_reg + IDW'(1);
                    res_status_next = sit_pkg::ST_OK;
                end else begin
                    b_next          = b_reg + BAW'(1);
                    probes_next     = probes_reg + PW'(1);
                    res_status_next = sit_pkg::ST_BAD_STATE;
                end
            end
            sit_pkg::S_CMP_CHK: begin
                i_next = i_reg + IW'(1);
                if (ts_q != wb_q) begin
                    b_next          = b_reg + BAW'(1);
                    probes_next     = probes_reg + PW'(1);
                    e_next          = e_reg + IDW'(1);
                    res_id_next     = '0;
                    res_found_next  = 1'b0;
                    res_status_next = (op_reg == sit_pkg::OP_INTERN) ?
                                      sit_pkg::ST_BAD_STATE : sit_pkg::ST_OK;
                end else begin
                    res_id_next     = e_reg + IDW'(1);
                    res_found_next  = (op_reg == sit_pkg::OP_LOOKUP);
                    res_status_next = sit_pkg::ST_OK;
                end
            end
            sit_pkg::S_LK_CHK: begin
                off_next = ent_off;
                i_next   = '0;
                if (ent_len_eq) begin
                    res_id_next    = e_reg + IDW'(1);
                    res_found_next = 1'b1;
                end else begin
                    e_next      = e_reg + IDW'(1);
                    res_id_next = '0;
                end
            end
            sit_pkg::S_INS: begin
                i_next          = '0;
                res_id_next     = '0;
                res_status_next = sit_pkg::ST_FULL;
            end
            sit_pkg::S_CP_WR: begin
                ts_we  = 1'b1;
                i_next = i_reg + IW'(1);
            end
            sit_pkg::S_CP_FIN: begin
                // terminator, entry record and bucket claim written in the same cycle
                ts_we           = 1'b1;
                ts_waddr        = SAW'(used_reg) + SAW'(word_len_reg);
                ts_wdata        = 8'd0;
                en_we           = 1'b1;
                bk_we           = 1'b1;
                used_next       = used_reg + UW'(word_len_reg) + UW'(1);
                count_next      = count_reg + IDW'(1);
                res_id_next     = count_reg + IDW'(1);
                res_status_next = sit_pkg::ST_OK;
            end
            sit_pkg::S_RB_ENT: begin
                off_next        = ent_off;
                rb_len_next     = IW'(rb_lim);
                i_next          = '0;
                res_id_next     = IDW'(q_reg);
                res_status_next = sit_pkg::ST_OK;
            end
            sit_pkg::S_RB_OUT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_symbol_id_next   = q_reg;
                    m_found_next       = 1'b0;
                    m_status_next      = sit_pkg::ST_OK;
                    m_text_out_next    = ts_q;
                    m_text_valid_next  = 1'b1;
                    m_last_result_next = rb_last;
                    i_next             = i_reg + IW'(1);
                end
            end
            sit_pkg::S_EMIT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_symbol_id_next   = 8'(res_id_reg);
                    m_found_next       = res_found_reg;
                    m_status_next      = res_status_reg;
                    m_text_out_next    = 8'd0;
                    m_text_valid_next  = 1'b0;
                    m_last_result_next = 1'b1;
                    if (clrw_reg) begin
                        word_len_next = '0;
                        too_long_next = 1'b0;
                        hash_next     = sit_pkg::FNV_BASIS;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sit_pkg::S_CLEAR;
            word_len_reg <= '0;
            too_long_reg <= 1'b0;
            hash_reg     <= sit_pkg::FNV_BASIS;
            count_reg    <= '0;
            used_reg     <= '0;
            b_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            word_len_reg <= word_len_next;
            too_long_reg <= too_long_next;
            hash_reg     <= hash_next;
            count_reg    <= count_next;
            used_reg     <= used_next;
            b_reg        <= b_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg            <= op_next;
        probes_reg        <= probes_next;
        e_reg             <= e_next;
        off_reg           <= off_next;
        i_reg             <= i_next;
        rb_len_reg        <= rb_len_next;
        q_reg             <= q_next;
        res_id_reg        <= res_id_next;
        res_found_reg     <= res_found_next;
        res_status_reg    <= res_status_next;
        clrw_reg          <= clrw_next;
        m_symbol_id_reg   <= m_symbol_id_next;
        m_found_reg       <= m_found_next;
        m_status_reg      <= m_status_next;
        m_text_out_reg    <= m_text_out_next;
        m_text_valid_reg  <= m_text_valid_next;
        m_last_result_reg <= m_last_result_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_symbol_id   = m_symbol_id_reg;
    assign m_found       = m_found_reg;
    assign m_status      = m_status_reg;
    assign m_text_out    = m_text_out_reg;
    assign m_text_valid  = m_text_valid_reg;
    assign m_last_result = m_last_result_reg;

    `SIT_ASSERT_IMPL(a_clear_blocks_input, aclk, aresetn, state_reg == sit_pkg::S_CLEAR, !s_ready, "input taken during bucket clear")
    `SIT_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= IDW'(MAX_ENTRIES), "symbol count beyond table size")
    `SIT_ASSERT_ALWAYS(a_store_bound, aclk, aresetn, used_reg <= UW'(STORE_BYTES), "text store overfilled")

endmodule

// ===== sv/sit_ram.sv =====
`timescale 1ns / 1ps

module sit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sit_hash.sv =====
`timescale 1ns / 1ps

module sit_hash (
    input  logic [sit_pkg::HASH_W-1:0] hash_in,
    input  logic [7:0]                 byte_in,
    output logic [sit_pkg::HASH_W-1:0] hash_out
);

    logic [sit_pkg::HASH_W-1:0] mixed;

    // fnv-1a: xor the byte in, then multiply by the prime modulo 2^32
    assign mixed    = hash_in ^ {{(sit_pkg::HASH_W-8){1'b0}}, byte_in};
    assign hash_out = sit_pkg::HASH_W'(mixed * sit_pkg::FNV_PRIME);

endmodule
